@@ rtl/core/pwot_pkg.sv @@
package pwot_pkg;

    localparam int SAMPLE_W = 14;
    localparam int RMS_W    = 13;
    localparam int WIN_W    = 10;
    localparam int FAULT_W  = 2;
    localparam int PEAK_AB_W = 14;
    localparam int PEAK_C_W  = 15;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RMS_TRIP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_TRIP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 2'd2;

    localparam logic [RMS_W-1:0] RMS_TRIP_RST  = 13'd8191;
    localparam logic [RMS_W-1:0] HARD_TRIP_RST = 13'd100;
    localparam logic [WIN_W-1:0] WIN_LEN_RST   = 10'd300;

    localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_WINDOW = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_HARD   = 2'd2;

    // 0.4 / 1.414 in Q16, rounded up
    localparam logic [29:0] RMS_GAIN = 30'd18540;
    localparam logic [RMS_W-1:0] RMS_MAX = 13'd8191;

    typedef logic [RMS_W-1:0] rms_t;

    function automatic rms_t to_rms(input logic [PEAK_C_W-1:0] peak);
        logic [29:0] prod;
        begin
            prod = {15'd0, peak} * RMS_GAIN;
            if (prod[29:16] > {1'b0, RMS_MAX})
                to_rms = RMS_MAX;
            else
                to_rms = prod[28:16];
        end
    endfunction

endpackage

@@ rtl/core/peak_window_overcurrent_trip.sv @@
// Throughput: one sample pair per cycle while the master side is not stalled;
// one input register, one compute stage (offset removal, peak hold, one
// constant multiply per phase, compares) and one result register.
// Reset (rst_n, asynchronous): offsets, peaks, window count, estimates and
// fault latch go to zero, registers to their defaults; no clearing pass.
module peak_window_overcurrent_trip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // phase_u_mv[13:0], phase_w_mv[27:14], zero fill
    input  logic [pwot_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // calibrate[0]
    input  logic [pwot_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rms_a[12:0], rms_b[25:13], rms_c[38:26], window_done[39], trip_now[40],
    // fault_code[42:41], zero fill
    output logic [pwot_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [pwot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pwot_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pwot_pkg::*;

    // configuration
    logic [RMS_W-1:0] rms_trip_reg;
    logic [RMS_W-1:0] hard_trip_reg;
    logic [WIN_W-1:0] win_len_reg;

    // input stage
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_u_reg;
    logic [SAMPLE_W-1:0] in_w_reg;
    logic                in_cal_reg;

    // state
    logic [SAMPLE_W-1:0]  offset_u_reg, offset_w_reg;
    logic [PEAK_AB_W-1:0] peak_a_reg, peak_b_reg;
    logic [PEAK_C_W-1:0]  peak_c_reg;
    logic [WIN_W-1:0]     count_reg;
    rms_t                 rms_a_reg, rms_b_reg, rms_c_reg;
    logic [FAULT_W-1:0]   fault_reg;

    // result stage
    logic               out_valid_reg;
    logic               out_done_reg;
    logic               out_trip_reg;

    logic advance;
    logic in_load;

    // compute
    logic [SAMPLE_W-1:0]  off_u, off_w;
    logic signed [14:0]   da, db;
    logic signed [15:0]   dc;
    logic [PEAK_AB_W-1:0] mag_a, mag_b;
    logic [PEAK_C_W-1:0]  mag_c;
    logic [PEAK_AB_W-1:0] peak_a_max, peak_b_max;
    logic [PEAK_C_W-1:0]  peak_c_max;
    logic [WIN_W-1:0]     count_inc;
    logic                 done;
    rms_t                 rms_a_new, rms_b_new, rms_c_new;
    rms_t                 rms_a_next, rms_b_next, rms_c_next;
    logic                 trip_window, trip_hard;
    logic [FAULT_W-1:0]   fault_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        off_u = in_cal_reg ? in_u_reg : offset_u_reg;
        off_w = in_cal_reg ? in_w_reg : offset_w_reg;
        da = 15'(signed'(in_u_reg)) - 15'(signed'(off_u));
        db = 15'(signed'(in_w_reg)) - 15'(signed'(off_w));
        dc = 16'(da) + 16'(db);
        mag_a = da[14] ? 14'(-da) : da[13:0];
        mag_b = db[14] ? 14'(-db) : db[13:0];
        mag_c = dc[15] ? 15'(-dc) : dc[14:0];

        peak_a_max = (mag_a > peak_a_reg) ? mag_a : peak_a_reg;
        peak_b_max = (mag_b > peak_b_reg) ? mag_b : peak_b_reg;
        peak_c_max = (mag_c > peak_c_reg) ? mag_c : peak_c_reg;

        count_inc = count_reg + 10'd1;
        done      = (count_inc == win_len_reg);

        rms_a_new = to_rms({1'b0, peak_a_max});
        rms_b_new = to_rms({1'b0, peak_b_max});
        rms_c_new = to_rms(peak_c_max);

        rms_a_next = done ? rms_a_new : rms_a_reg;
        rms_b_next = done ? rms_b_new : rms_b_reg;
        rms_c_next = done ? rms_c_new : rms_c_reg;

        trip_window = done && ((rms_a_new > rms_trip_reg) || (rms_b_new > rms_trip_reg)
                               || (rms_c_new > rms_trip_reg));
        // hard check sees the estimates just latched on this sample
        trip_hard = (rms_a_next > hard_trip_reg) || (rms_b_next > hard_trip_reg)
                    || (rms_c_next > hard_trip_reg);

        if (trip_hard)
            fault_next = FAULT_HARD;
        else if (trip_window)
            fault_next = FAULT_WINDOW;
        else
            fault_next = fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rms_trip_reg  <= RMS_TRIP_RST;
            hard_trip_reg <= HARD_TRIP_RST;
            win_len_reg   <= WIN_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RMS_TRIP:  rms_trip_reg  <= cfg_data;
                REG_HARD_TRIP: hard_trip_reg <= cfg_data;
                REG_WIN_LEN:   win_len_reg   <= cfg_data[WIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_u_reg  <= '0;
            offset_w_reg  <= '0;
            peak_a_reg    <= '0;
            peak_b_reg    <= '0;
            peak_c_reg    <= '0;
            count_reg     <= '0;
            rms_a_reg     <= '0;
            rms_b_reg     <= '0;
            rms_c_reg     <= '0;
            fault_reg     <= FAULT_NONE;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                offset_u_reg <= off_u;
                offset_w_reg <= off_w;
                peak_a_reg   <= done ? '0 : peak_a_max;
                peak_b_reg   <= done ? '0 : peak_b_max;
                peak_c_reg   <= done ? '0 : peak_c_max;
                count_reg    <= done ? '0 : count_inc;
                rms_a_reg    <= rms_a_next;
                rms_b_reg    <= rms_b_next;
                rms_c_reg    <= rms_c_next;
                fault_reg    <= fault_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_u_reg   <= s_axis_tdata[SAMPLE_W-1:0];
            in_w_reg   <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
            in_cal_reg <= s_axis_tuser[0];
        end
        if (advance)
        begin
            out_done_reg <= done;
            out_trip_reg <= trip_window || trip_hard;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, fault_reg, out_trip_reg, out_done_reg,
                            rms_c_reg, rms_b_reg, rms_a_reg};

endmodule

@@ rtl/core/pwot_checker.sv @@
module pwot_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pwot_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pwot_pkg::*;

    logic [FAULT_W-1:0] fault;
    logic               done;
    logic               trip;

    assign fault = m_axis_tdata[42:41];
    assign trip  = m_axis_tdata[40];
    assign done  = m_axis_tdata[39];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an empty result stage never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    a_trip_latched: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && trip |-> fault != FAULT_NONE)
        else $error("trip without latched fault");

    // outside a window end only the hard limit can fire
    a_trip_hard: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && trip && !done |-> fault == FAULT_HARD)
        else $error("mid-window trip not a hard fault");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> fault == FAULT_NONE || fault == FAULT_WINDOW
                          || fault == FAULT_HARD)
        else $error("fault code out of range");

endmodule

bind peak_window_overcurrent_trip pwot_checker u_pwot_checker (.*);

@@ sim/peak_window_overcurrent_trip_checker.sv @@
`timescale 1ns / 1ps

module peak_window_overcurrent_trip_checker
    import pwot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // phase_u_mv[13:0], phase_w_mv[27:14], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // calibrate[0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rms_a[12:0], rms_b[25:13], rms_c[38:26], window_done[39], trip_now[40],
    // fault_code[42:41], zero fill
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    fail_count
);

    typedef struct packed {
        rms_t               rms_a;
        rms_t               rms_b;
        rms_t               rms_c;
        logic               done;
        logic               trip;
        logic [FAULT_W-1:0] fault;
    } trip_status_t;

    trip_status_t expected_status_q[$];

    // register copies
    rms_t             window_trip_level;
    rms_t             hard_trip_level;
    logic [WIN_W-1:0] window_len;

    // axis state
    int               offset_u;
    int               offset_w;
    int unsigned      peak_a;
    int unsigned      peak_b;
    int unsigned      peak_c;
    logic [WIN_W-1:0] window_count;
    rms_t             rms_est [3];
    logic [FAULT_W-1:0] fault_latch;
    int               failures;

    function automatic rms_t peak_to_rms(input int unsigned peak);
        int unsigned scaled;
        scaled = (peak * RMS_GAIN) >> 16;
        if (scaled > RMS_MAX)
            return RMS_MAX;
        return rms_t'(scaled);
    endfunction

    task automatic predict_sample(input logic [SAMPLE_W-1:0] u_raw,
                                  input logic [SAMPLE_W-1:0] w_raw,
                                  input logic cal, output trip_status_t st);
        int          su;
        int          sw;
        int          da;
        int          db;
        int          dc;
        int unsigned ma;
        int unsigned mb;
        int unsigned mc;
        int          k;
        su = $signed(u_raw);
        sw = $signed(w_raw);
        st = '0;
        if (cal)
        begin
            offset_u = su;
            offset_w = sw;
        end
        da = su - offset_u;
        db = sw - offset_w;
        dc = da + db;
        ma = (da < 0) ? -da : da;
        mb = (db < 0) ? -db : db;
        mc = (dc < 0) ? -dc : dc;
        if (ma > peak_a) peak_a = ma;
        if (mb > peak_b) peak_b = mb;
        if (mc > peak_c) peak_c = mc;

        // count wraps at 1024, so a length of zero closes every 1024 samples
        window_count = window_count + 1'b1;
        if (window_count == window_len)
        begin
            st.done = 1'b1;
            window_count = '0;
            rms_est[0] = peak_to_rms(peak_a);
            rms_est[1] = peak_to_rms(peak_b);
            rms_est[2] = peak_to_rms(peak_c);
            peak_a = 0;
            peak_b = 0;
            peak_c = 0;
            for (k = 0; k < 3; k++)
            begin
                if (rms_est[k] > window_trip_level)
                begin
                    fault_latch = FAULT_WINDOW;
                    st.trip = 1'b1;
                end
            end
        end
        // hard check runs after the window check, so it wins on the same sample
        for (k = 0; k < 3; k++)
        begin
            if (rms_est[k] > hard_trip_level)
            begin
                fault_latch = FAULT_HARD;
                st.trip = 1'b1;
            end
        end
        st.rms_a = rms_est[0];
        st.rms_b = rms_est[1];
        st.rms_c = rms_est[2];
        st.fault = fault_latch;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        trip_status_t want;
        trip_status_t got;
        if (!rst_n)
        begin
            window_trip_level = RMS_TRIP_RST;
            hard_trip_level   = HARD_TRIP_RST;
            window_len        = WIN_LEN_RST;
            offset_u          = 0;
            offset_w          = 0;
            peak_a            = 0;
            peak_b            = 0;
            peak_c            = 0;
            window_count      = '0;
            rms_est[0]        = '0;
            rms_est[1]        = '0;
            rms_est[2]        = '0;
            fault_latch       = FAULT_NONE;
            failures          = 0;
            expected_status_q.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RMS_TRIP:  window_trip_level = cfg_data[RMS_W-1:0];
                    REG_HARD_TRIP: hard_trip_level   = cfg_data[RMS_W-1:0];
                    REG_WIN_LEN:   window_len        = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            // results first: a result cannot belong to a sample taken on this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.rms_a = m_axis_tdata[12:0];
                got.rms_b = m_axis_tdata[25:13];
                got.rms_c = m_axis_tdata[38:26];
                got.done  = m_axis_tdata[39];
                got.trip  = m_axis_tdata[40];
                got.fault = m_axis_tdata[42:41];
                if (expected_status_q.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: unexpected result rms %0d/%0d/%0d done %0d trip %0d fault %0d",
                                 $time, got.rms_a, got.rms_b, got.rms_c, got.done, got.trip,
                                 got.fault);
                    failures++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got.rms_a != want.rms_a || got.rms_b != want.rms_b ||
                        got.rms_c != want.rms_c || got.done != want.done ||
                        got.trip != want.trip || got.fault != want.fault)
                    begin
                        if (failures < 10)
                        begin
                            $display("%0t: mismatch exp rms %0d/%0d/%0d done %0d trip %0d fault %0d",
                                     $time, want.rms_a, want.rms_b, want.rms_c, want.done,
                                     want.trip, want.fault);
                            $display("%0t:          got rms %0d/%0d/%0d done %0d trip %0d fault %0d",
                                     $time, got.rms_a, got.rms_b, got.rms_c, got.done,
                                     got.trip, got.fault);
                        end
                        failures++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_sample(s_axis_tdata[13:0], s_axis_tdata[27:14], s_axis_tuser[0], want);
                expected_status_q.push_back(want);
            end

            pending    <= expected_status_q.size();
            fail_count <= failures;
        end
    end

endmodule

@@ sim/peak_window_overcurrent_trip_test.sv @@
`timescale 1ns / 1ps

module peak_window_overcurrent_trip_test;
    import pwot_pkg::*;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // phase_u_mv[13:0], phase_w_mv[27:14], zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // calibrate[0]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // rms_a[12:0], rms_b[25:13], rms_c[38:26], window_done[39], trip_now[40],
    // fault_code[42:41], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_RMS_TRIP;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    int                    pending;
    int                    fail_count;

    int                    tx_calm_left  = 0;
    bit                    tx_calm       = 1'b0;

    always #2 clk = ~clk;

    peak_window_overcurrent_trip u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    peak_window_overcurrent_trip_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int draw_gap();
        if (tx_calm_left == 0)
        begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_calm_left = $urandom_range(10, 80);
        end
        else
            tx_calm_left--;
        if (tx_calm)
            return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7, 8:    return $urandom_range(1, 3);
            default:       return $urandom_range(6, 30);
        endcase
    endfunction

    function automatic int draw_sample(input int amp);
        if ($urandom_range(0, 29) == 0)
            return int'($urandom_range(0, 16383));
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    task automatic send_sample(input int u, input int w, input bit cal);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, 14'(w), 14'(u)};
        s_axis_tuser  <= cal;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(input int trip_lvl, input int hard_lvl, input int win_len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RMS_TRIP;
        cfg_data  <= CFG_DATA_W'(trip_lvl);
        @(posedge clk);
        cfg_index <= REG_HARD_TRIP;
        cfg_data  <= CFG_DATA_W'(hard_lvl);
        @(posedge clk);
        cfg_index <= REG_WIN_LEN;
        cfg_data  <= CFG_DATA_W'(win_len);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_axis_traffic(input int count);
        int amp;
        int k;
        amp = 1000;
        for (k = 0; k < count; k++)
        begin
            // hold an amplitude for a while so window peaks land near the limits
            if (k % 16 == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       amp = 50;
                    1:       amp = 400;
                    2:       amp = 1500;
                    3:       amp = 3000;
                    default: amp = 5000;
                endcase
            end
            send_sample(draw_sample(amp), draw_sample(amp), $urandom_range(0, 39) == 0);
        end
    endtask

    initial
    begin : sink
        int  stall_left;
        int  calm_left;
        bit  calm;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(20, 120);
            end
            else
                calm_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: long window, no close
        send_sample(0, 0, 1'b0);
        send_sample(5000, -5000, 1'b0);
        send_sample(-5000, 5000, 1'b0);
        wait_drained();

        // field extremes; saturated estimate sits exactly on the levels
        program_limits(8191, 8191, 4);
        send_sample(8191, 8191, 1'b0);
        send_sample(-8192, -8192, 1'b1);
        send_sample(8191, 8191, 1'b0);
        send_sample(-8192, 8191, 1'b0);
        send_sample(8191, -8192, 1'b0);
        send_sample(0, 0, 1'b1);
        send_sample(1, -1, 1'b0);
        send_sample(-1, 1, 1'b0);
        send_sample(0, 1, 1'b0);
        wait_drained();

        // window trip only
        program_limits(0, 8191, 2);
        send_sample(100, 0, 1'b0);
        send_sample(0, 0, 1'b0);
        wait_drained();

        // hard trip from latched estimates, until the quiet window closes
        program_limits(0, 10, 2);
        send_sample(0, 0, 1'b0);
        send_sample(0, 0, 1'b0);
        wait_drained();

        // window and hard trip on the same sample
        program_limits(0, 0, 1);
        send_sample(200, 0, 1'b0);
        send_sample(0, 0, 1'b0);
        wait_drained();

        program_limits(8191, 8191, 1);
        run_axis_traffic(60);
        wait_drained();
        program_limits(0, 8191, 7);
        run_axis_traffic(60);
        wait_drained();
        program_limits(1500, 2500, 16);
        run_axis_traffic(50);
        wait_drained();
        program_limits(700, 8191, 33);
        run_axis_traffic(70);
        wait_drained();
        program_limits(3000, 100, 5);
        run_axis_traffic(60);
        wait_drained();
        program_limits(8191, 0, 2);
        run_axis_traffic(40);
        wait_drained();
        program_limits(1200, 1800, 12);
        run_axis_traffic(50);
        wait_drained();

        // length dropped below the running count: no close until the count wraps
        program_limits(2000, 4000, 40);
        run_axis_traffic(30);
        wait_drained();
        program_limits(2000, 4000, 8);
        run_axis_traffic(20);
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(64'd8_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
